>>> rtl/core/bll_pkg.sv
// Shared types and constants for the bounded list bank.
// No dependencies; imported by the top, bll_ctrl, bll_dp and the testbench, not by bll_ram.
`default_nettype none
package bll_pkg;
    localparam int MODE_W      = 3;
    localparam int SLOT_W      = 4;
    localparam int WORD_W      = 32;
    localparam int SIZE_W      = 6;
    localparam int OUT_CNT_W   = 5;
    localparam int MAX_RESULTS = 16;

    typedef enum logic [3:0] {
        ST_OK, ST_BAD_SLOT, ST_BAD_SIZE, ST_EXISTS, ST_TOO_BIG,
        ST_FULL, ST_NO_SLOT, ST_EMPTY, ST_NOT_FOUND, ST_BAD_NEW_SIZE
    } t_status;

    typedef enum logic [2:0] {
        MD_CREATE, MD_APPEND, MD_DROP, MD_REMOVE,
        MD_RESIZE, MD_READ, MD_SORT, MD_COUNT
    } t_mode;

    typedef enum logic [1:0] {OP_SINGLE, OP_READ, OP_SORT, OP_REMOVE} t_op;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_SINGLE, S_RD_ADDR, S_RD_DATA,
        S_SORT_EMIT, S_RM_ADDR, S_RM_DATA, S_RM_DONE
    } t_state;

    typedef struct packed {
        logic take;
        logic single;
        logic idx_clr;
        logic idx_inc;
        logic rd_req;
        logic emit_mem;
        logic ins;
        logic emit_buf;
        logic rm_step;
        logic rm_done;
    } t_cmd;

    typedef struct packed {
        t_op  op;
        logic out_free;
        logic at_fill_end;
        logic at_out_end;
    } t_sts;
endpackage
`default_nettype wire

>>> rtl/core/bounded_list_bank.sv
// Bounded list bank: one request at a time, accepted in the cycle after the previous
// result is issued. Single-result requests pass accept, decode and emit; a read takes an
// address and a data step per emitted word and a remove per stored word, a sorted read
// loads each word into the insertion buffer, then emits from it. Results wait for output.
// Sync active-low reset empties all slots at once;
// element RAM is not cleared, only words below a slot's fill are ever read.
`default_nettype none
module bounded_list_bank
    import bll_pkg::*;
#(
    parameter int NUM_SLOTS    = 10,
    parameter int MAX_CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [47:0] i_s_tdata,   // slot[3:0], item_value[35:4], size_value[41:36]
    input  wire logic [2:0]  i_s_tuser,   // mode[2:0]
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [47:0]      o_m_tdata,   // status[3:0], data_word[35:4], item_count[40:36]
    output logic [0:0]       o_m_tuser,   // data_valid[0]
    output logic             o_m_tlast    // last_result
);
    t_cmd    cmd;
    t_sts    sts;
    t_status status;
    logic [WORD_W-1:0]    data_word;
    logic [OUT_CNT_W-1:0] item_count;
    logic                 data_valid;

    bll_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    bll_dp #(
        .NUM_SLOTS    (NUM_SLOTS),
        .MAX_CAPACITY (MAX_CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_mode        (i_s_tuser),
        .i_slot        (i_s_tdata[3:0]),
        .i_item_value  (i_s_tdata[35:4]),
        .i_size_value  (i_s_tdata[41:36]),
        .i_m_tready    (i_m_tready),
        .o_m_tvalid    (o_m_tvalid),
        .o_status      (status),
        .o_data_word   (data_word),
        .o_data_valid  (data_valid),
        .o_item_count  (item_count),
        .o_last_result (o_m_tlast)
    );

    assign o_m_tdata = {7'b0, item_count, data_word, status};
    assign o_m_tuser = data_valid;
endmodule
`default_nettype wire

>>> rtl/core/bll_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module bll_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 160,
    parameter int ADDR_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output logic      [WIDTH-1:0]  o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

>>> rtl/core/bll_ctrl.sv
// Sequencer for the bounded list bank: one request at a time.
// Depends on bll_pkg; drives bll_dp through t_cmd, reads t_sts.
`default_nettype none
module bll_ctrl
    import bll_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_s_tvalid,
    output logic      o_s_tready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);
    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_tvalid) n_state = S_DECODE;
            S_DECODE: begin
                unique case (i_sts.op)
                    OP_SINGLE: n_state = S_SINGLE;
                    OP_REMOVE: n_state = S_RM_ADDR;
                    default:   n_state = S_RD_ADDR;
                endcase
            end
            S_SINGLE:  if (i_sts.out_free) n_state = S_IDLE;
            S_RD_ADDR: n_state = S_RD_DATA;
            S_RD_DATA: begin
                if (i_sts.op == OP_SORT) begin
                    n_state = i_sts.at_fill_end ? S_SORT_EMIT : S_RD_ADDR;
                end else if (i_sts.out_free) begin
                    n_state = i_sts.at_out_end ? S_IDLE : S_RD_ADDR;
                end
            end
            S_SORT_EMIT: if (i_sts.out_free && i_sts.at_out_end) n_state = S_IDLE;
            S_RM_ADDR:   n_state = S_RM_DATA;
            S_RM_DATA:   n_state = i_sts.at_fill_end ? S_RM_DONE : S_RM_ADDR;
            S_RM_DONE:   if (i_sts.out_free) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_s_tready = 1'b1;
                o_cmd.take = i_s_tvalid;
            end
            S_DECODE:  o_cmd.idx_clr = 1'b1;
            S_SINGLE:  o_cmd.single  = i_sts.out_free;
            S_RD_ADDR, S_RM_ADDR: o_cmd.rd_req = 1'b1;
            S_RD_DATA: begin
                if (i_sts.op == OP_SORT) begin
                    // buffer fill equals the index, so the last insert resets it
                    o_cmd.ins     = 1'b1;
                    o_cmd.idx_inc = !i_sts.at_fill_end;
                    o_cmd.idx_clr = i_sts.at_fill_end;
                end else begin
                    o_cmd.emit_mem = i_sts.out_free;
                    o_cmd.idx_inc  = i_sts.out_free;
                end
            end
            S_SORT_EMIT: begin
                o_cmd.emit_buf = i_sts.out_free;
                o_cmd.idx_inc  = i_sts.out_free;
            end
            S_RM_DATA: begin
                o_cmd.rm_step = 1'b1;
                o_cmd.idx_inc = 1'b1;
            end
            S_RM_DONE: o_cmd.rm_done = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end
endmodule
`default_nettype wire

>>> rtl/core/bll_dp.sv
// Datapath of the bounded list bank: slot tables, element RAM, sort buffer,
// output register. Depends on bll_pkg and bll_ram; steered by bll_ctrl.
`default_nettype none
module bll_dp
    import bll_pkg::*;
#(
    parameter int NUM_SLOTS    = 10,
    parameter int MAX_CAPACITY = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire t_cmd                     i_cmd,
    output t_sts                          o_sts,
    input  wire logic [MODE_W-1:0]        i_mode,
    input  wire logic [SLOT_W-1:0]        i_slot,
    input  wire logic [WORD_W-1:0]        i_item_value,
    input  wire logic [SIZE_W-1:0]        i_size_value,
    input  wire logic                     i_m_tready,
    output logic                          o_m_tvalid,
    output t_status                       o_status,
    output logic [WORD_W-1:0]             o_data_word,
    output logic                          o_data_valid,
    output logic [OUT_CNT_W-1:0]          o_item_count,
    output logic                          o_last_result
);
    localparam int CW    = $clog2(MAX_CAPACITY + 1);
    localparam int IW    = (MAX_CAPACITY > 1) ? $clog2(MAX_CAPACITY) : 1;
    localparam int SIW   = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
    localparam int DEPTH = NUM_SLOTS * MAX_CAPACITY;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic signed [8:0] MAXC_S = 9'(MAX_CAPACITY);

    t_mode                    r_mode;
    logic [SLOT_W-1:0]        r_slot;
    logic [WORD_W-1:0]        r_value;
    logic signed [SIZE_W-1:0] r_size;

    logic          r_present [NUM_SLOTS];
    logic [CW-1:0] r_cap     [NUM_SLOTS];
    logic [CW-1:0] r_fill    [NUM_SLOTS];

    logic [IW-1:0]            r_idx;
    logic                     r_found;
    logic signed [WORD_W-1:0] r_sbuf [MAX_CAPACITY];
    logic                     r_ovld;

    logic                     slot_ok, pres;
    logic [SIW-1:0]           s_idx;
    logic [CW-1:0]            cap, fill, n_m1;
    logic [AW-1:0]            base;
    logic signed [8:0]        size_x, newcap;
    logic signed [WORD_W-1:0] rdata;
    logic                     out_free;
    logic [MAX_CAPACITY-1:0]  lt;

    t_status       sg_st;
    logic [CW-1:0] sg_cnt, sg_cap, sg_fill;
    logic          sg_tab, sg_ram;

    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;

    function automatic logic i_slot_ok_chk(input logic [SLOT_W-1:0] s);
        return (s >= SLOT_W'(1)) && (int'(s) <= NUM_SLOTS);
    endfunction

    assign slot_ok = (i_slot_ok_chk(r_slot));
    assign s_idx   = SIW'(r_slot - SLOT_W'(1));
    assign pres    = slot_ok && r_present[s_idx];
    assign cap     = r_cap[s_idx];
    assign fill    = slot_ok ? r_fill[s_idx] : '0;
    assign base    = AW'(32'(s_idx) * MAX_CAPACITY);
    assign size_x  = {{(9 - SIZE_W){r_size[SIZE_W-1]}}, r_size};
    assign newcap  = signed'(9'(cap)) + size_x;
    assign n_m1    = (int'(fill) > MAX_RESULTS) ? CW'(MAX_RESULTS - 1) : fill - CW'(1);
    assign out_free = !r_ovld || i_m_tready;

    always_comb begin
        o_sts.out_free    = out_free;
        o_sts.at_fill_end = (CW'(r_idx) == fill - CW'(1));
        o_sts.at_out_end  = (CW'(r_idx) == n_m1);
        o_sts.op          = OP_SINGLE;
        if (pres && fill != '0) begin
            case (r_mode) inside
                MD_READ:   o_sts.op = OP_READ;
                MD_SORT:   o_sts.op = OP_SORT;
                MD_REMOVE: o_sts.op = OP_REMOVE;
                default:   o_sts.op = OP_SINGLE;
            endcase
        end
    end

    // single-result operations
    always_comb begin
        sg_st   = ST_OK;
        sg_cnt  = fill;
        sg_tab  = 1'b0;
        sg_cap  = cap;
        sg_fill = fill;
        sg_ram  = 1'b0;
        if (!slot_ok) begin
            sg_st  = ST_BAD_SLOT;
            sg_cnt = '0;
        end else if (r_mode == MD_CREATE) begin
            if (size_x < 9'sd1) begin
                sg_st = ST_BAD_SIZE;
            end else if (pres) begin
                sg_st = ST_EXISTS;
            end else if (size_x > MAXC_S) begin
                sg_st = ST_TOO_BIG;
            end else begin
                sg_tab  = 1'b1;
                sg_cap  = size_x[CW-1:0];
                sg_fill = '0;
                sg_cnt  = '0;
            end
        end else if (!pres) begin
            sg_st  = ST_NO_SLOT;
            sg_cnt = '0;
        end else begin
            case (r_mode) inside
                MD_APPEND: begin
                    if (fill >= cap || int'(fill) >= MAX_CAPACITY) begin
                        sg_st = ST_FULL;
                    end else begin
                        sg_ram  = 1'b1;
                        sg_tab  = 1'b1;
                        sg_fill = fill + CW'(1);
                        sg_cnt  = fill + CW'(1);
                    end
                end
                MD_DROP: begin
                    if (fill == '0) begin
                        sg_st = ST_EMPTY;
                    end else begin
                        sg_tab  = 1'b1;
                        sg_fill = fill - CW'(1);
                        sg_cnt  = fill - CW'(1);
                    end
                end
                MD_REMOVE: sg_st = ST_NOT_FOUND;
                MD_RESIZE: begin
                    if (newcap < 9'sd1) begin
                        sg_st = ST_BAD_NEW_SIZE;
                    end else if (newcap > MAXC_S) begin
                        sg_st = ST_TOO_BIG;
                    end else begin
                        sg_tab = 1'b1;
                        sg_cap = newcap[CW-1:0];
                        if (fill > newcap[CW-1:0]) begin
                            sg_fill = newcap[CW-1:0];
                            sg_cnt  = newcap[CW-1:0];
                        end
                    end
                end
                MD_READ, MD_SORT: sg_cnt = '0;
                default: if (fill == '0) sg_st = ST_EMPTY;
            endcase
        end
    end

    // ordered insertion: positions at or past the insert point shift up
    always_comb begin
        for (int k = 0; k < MAX_CAPACITY; k++) begin
            lt[k] = (k >= int'(r_idx)) || (rdata < r_sbuf[k]);
        end
    end

    assign ram_re    = i_cmd.rd_req;
    assign ram_raddr = base + AW'(r_idx);
    assign ram_we    = (i_cmd.single && sg_ram) || (i_cmd.rm_step && r_found);
    assign ram_waddr = i_cmd.single ? base + AW'(fill) : base + AW'(r_idx) - AW'(1);

    bll_ram #(
        .WIDTH  (WORD_W),
        .DEPTH  (DEPTH),
        .ADDR_W (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_cmd.single ? r_value : rdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_mode  <= t_mode'(i_mode);
            r_slot  <= i_slot;
            r_value <= i_item_value;
            r_size  <= i_size_value;
        end
        if (i_cmd.ins) begin
            for (int k = 0; k < MAX_CAPACITY; k++) begin
                if (lt[k]) begin
                    r_sbuf[k] <= (k > 0 && lt[(k > 0) ? k - 1 : 0]) ?
                                 r_sbuf[(k > 0) ? k - 1 : 0] : rdata;
                end
            end
        end
        if (i_cmd.single) begin
            o_status      <= sg_st;
            o_data_word   <= '0;
            o_data_valid  <= 1'b0;
            o_item_count  <= OUT_CNT_W'(sg_cnt);
            o_last_result <= 1'b1;
        end else if (i_cmd.emit_mem || i_cmd.emit_buf) begin
            o_status      <= ST_OK;
            o_data_word   <= i_cmd.emit_mem ? rdata : r_sbuf[r_idx];
            o_data_valid  <= 1'b1;
            o_item_count  <= OUT_CNT_W'(fill);
            o_last_result <= o_sts.at_out_end;
        end else if (i_cmd.rm_done) begin
            o_status      <= r_found ? ST_OK : ST_NOT_FOUND;
            o_data_word   <= '0;
            o_data_valid  <= 1'b0;
            o_item_count  <= OUT_CNT_W'(r_found ? fill - CW'(1) : fill);
            o_last_result <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovld  <= 1'b0;
            r_idx   <= '0;
            r_found <= 1'b0;
            for (int k = 0; k < NUM_SLOTS; k++) begin
                r_present[k] <= 1'b0;
                r_cap[k]     <= '0;
                r_fill[k]    <= '0;
            end
        end else begin
            if (i_cmd.single || i_cmd.emit_mem || i_cmd.emit_buf || i_cmd.rm_done) begin
                r_ovld <= 1'b1;
            end else if (i_m_tready) begin
                r_ovld <= 1'b0;
            end
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + IW'(1);
            end
            if (i_cmd.idx_clr && !i_cmd.ins) begin
                r_found <= 1'b0;
            end else if (i_cmd.rm_step && !r_found && rdata == signed'(r_value)) begin
                r_found <= 1'b1;
            end
            if (i_cmd.single && sg_tab) begin
                r_present[s_idx] <= 1'b1;
                r_cap[s_idx]     <= sg_cap;
                r_fill[s_idx]    <= sg_fill;
            end else if (i_cmd.rm_done && r_found) begin
                r_fill[s_idx] <= fill - CW'(1);
            end
        end
    end

    assign o_m_tvalid = r_ovld;
endmodule
`default_nettype wire

>>> tb/bounded_list_bank_checker.sv
// Checker for the bounded list bank: watches both stream channels, keeps its own
// copy of the slot bank, predicts every response and compares it. Depends on bll_pkg.
`default_nettype none
module bounded_list_bank_checker
    import bll_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [47:0] i_s_tdata,   // slot[3:0], item_value[35:4], size_value[41:36]
    input  wire logic [2:0]  i_s_tuser,   // mode[2:0]
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [47:0] i_m_tdata,   // status[3:0], data_word[35:4], item_count[40:36]
    input  wire logic [0:0]  i_m_tuser,   // data_valid[0]
    input  wire logic        i_m_tlast,
    output int               o_fail_count,
    output int               o_pending,
    output int               o_responses
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOT = 10;
    localparam int MAXCAP = 16;

    typedef struct packed {
        t_status     status;
        logic [31:0] word;
        logic        word_valid;
        logic [4:0]  count;
        logic        last;
    } t_resp;

    t_resp       resp_q[$];
    logic        present[NSLOT];
    int          capacity[NSLOT];
    int          fill[NSLOT];
    logic [31:0] words[NSLOT][MAXCAP];

    task automatic report(input string what, input t_resp got, input t_resp want);
        o_fail_count++;
        $display("mismatch %s: got st=%0d w=%h v=%b n=%0d l=%b, want st=%0d w=%h v=%b n=%0d l=%b",
                 what, got.status, got.word, got.word_valid, got.count, got.last,
                 want.status, want.word, want.word_valid, want.count, want.last);
    endtask

    function automatic t_resp mk(t_status st, logic [31:0] w, logic v, int n, logic l);
        t_resp r;
        r.status = st; r.word = w; r.word_valid = v; r.count = n[4:0]; r.last = l;
        return r;
    endfunction

    task automatic predict_request(input t_mode md, input logic [3:0] sl,
                                   input logic [31:0] val, input logic signed [5:0] sz);
        int          s, n, k, newcap;
        t_status     st;
        logic [31:0] buf_w[MAXCAP];
        logic [31:0] t;
        st = ST_OK;
        if (sl < 1 || sl > NSLOT) begin
            resp_q.push_back(mk(ST_BAD_SLOT, 0, 0, 0, 1));
            return;
        end
        s = sl - 1;
        if (md == MD_CREATE) begin
            if (sz < 1) st = ST_BAD_SIZE;
            else if (present[s]) st = ST_EXISTS;
            else if (sz > MAXCAP) st = ST_TOO_BIG;
            else begin
                present[s] = 1; capacity[s] = sz; fill[s] = 0;
            end
            resp_q.push_back(mk(st, 0, 0, fill[s], 1));
            return;
        end
        if (!present[s]) begin
            resp_q.push_back(mk(ST_NO_SLOT, 0, 0, 0, 1));
            return;
        end
        n = fill[s];
        case (md)
            MD_APPEND: begin
                if (n >= capacity[s]) st = ST_FULL;
                else begin
                    words[s][n] = val; fill[s] = n + 1;
                end
            end
            MD_DROP: begin
                if (n == 0) st = ST_EMPTY;
                else fill[s] = n - 1;
            end
            MD_REMOVE: begin
                st = ST_NOT_FOUND;
                for (int i = 0; i < n; i++) begin
                    if (words[s][i] == val) begin
                        for (int j = i; j + 1 < n; j++) words[s][j] = words[s][j + 1];
                        fill[s] = n - 1;
                        st = ST_OK;
                        break;
                    end
                end
            end
            MD_RESIZE: begin
                newcap = capacity[s] + int'(sz);
                if (newcap < 1) st = ST_BAD_NEW_SIZE;
                else if (newcap > MAXCAP) st = ST_TOO_BIG;
                else begin
                    capacity[s] = newcap;
                    if (n > newcap) fill[s] = newcap;
                end
            end
            MD_READ, MD_SORT: begin
                if (n == 0) begin
                    resp_q.push_back(mk(ST_OK, 0, 0, 0, 1));
                    return;
                end
                for (int i = 0; i < n; i++) buf_w[i] = words[s][i];
                if (md == MD_SORT) begin
                    for (int j = n - 1; j >= 1; j--)
                        for (int i = 0; i < j; i++)
                            if ($signed(buf_w[i]) > $signed(buf_w[i + 1])) begin
                                t = buf_w[i]; buf_w[i] = buf_w[i + 1]; buf_w[i + 1] = t;
                            end
                end
                k = (n > MAX_RESULTS) ? MAX_RESULTS : n;
                for (int i = 0; i < k; i++)
                    resp_q.push_back(mk(ST_OK, buf_w[i], 1, n, i == k - 1));
                return;
            end
            default: begin
                if (n == 0) st = ST_EMPTY;
            end
        endcase
        resp_q.push_back(mk(st, 0, 0, fill[s], 1));
    endtask

    initial begin
        o_fail_count = 0;
        o_responses = 0;
        for (int i = 0; i < NSLOT; i++) begin
            present[i] = 0; capacity[i] = 0; fill[i] = 0;
        end
    end

    assign o_pending = resp_q.size();

    always @(posedge i_clk) begin
        t_resp got, want;
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready)
                predict_request(t_mode'(i_s_tuser), i_s_tdata[3:0], i_s_tdata[35:4],
                                i_s_tdata[41:36]);
            if (i_m_tvalid && i_m_tready) begin
                got = mk(t_status'(i_m_tdata[3:0]), i_m_tdata[35:4], i_m_tuser[0],
                         i_m_tdata[40:36], i_m_tlast);
                o_responses++;
                if (resp_q.size() == 0) begin
                    report("unexpected response", got, got);
                end else begin
                    want = resp_q.pop_front();
                    if (got.status != want.status) report("status", got, want);
                    else if (got.word != want.word) report("data_word", got, want);
                    else if (got.word_valid != want.word_valid) report("data_valid", got, want);
                    else if (got.count != want.count) report("item_count", got, want);
                    else if (got.last != want.last) report("last", got, want);
                end
            end
        end
    end
endmodule
`default_nettype wire

>>> tb/bounded_list_bank_tb.sv
// Top of the bounded list bank testbench: clock, reset, request stimulus and
// response back-pressure. Depends on bll_pkg, bounded_list_bank and the checker.
`default_nettype none
module bounded_list_bank_tb;
    import bll_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;  // slot[3:0], item_value[35:4], size_value[41:36]
    logic [2:0]  s_tuser = '0;  // mode[2:0]
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [47:0] m_tdata;       // status[3:0], data_word[35:4], item_count[40:36]
    logic [0:0]  m_tuser;       // data_valid[0]
    logic        m_tlast;
    int          fail_count, pending, responses;
    int          sent = 0;
    bit          hold_off = 0;
    bit          stall_mode = 0;

    always #1 i_clk = ~i_clk;

    bounded_list_bank i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .o_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .o_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .o_m_tdata(m_tdata), .o_m_tuser(m_tuser), .o_m_tlast(m_tlast)
    );

    bounded_list_bank_checker i_chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_tvalid), .i_s_tready(s_tready),
        .i_s_tdata(s_tdata), .i_s_tuser(s_tuser),
        .i_m_tvalid(m_tvalid), .i_m_tready(m_tready),
        .i_m_tdata(m_tdata), .i_m_tuser(m_tuser), .i_m_tlast(m_tlast),
        .o_fail_count(fail_count), .o_pending(pending), .o_responses(responses)
    );

    // receiver: alternates between free-running and random stall patterns, unless held off
    always @(posedge i_clk) begin
        if (hold_off)
            m_tready <= 0;
        else if (($urandom % 64) == 0)
            stall_mode <= ~stall_mode;
        if (!hold_off)
            m_tready <= stall_mode ? (($urandom % 4) != 0) : 1'b1;
    end

    // sends one request; a burst gap of zero keeps tvalid high across requests
    task automatic send(input t_mode md, input logic [3:0] sl, input logic [31:0] val,
                        input logic signed [5:0] sz);
        s_tvalid <= 1;
        s_tuser  <= md;
        s_tdata  <= {6'b0, sz, val, sl};
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        sent++;
    endtask

    task automatic gap();
        int g;
        g = (($urandom % 5) == 0) ? 0 : $urandom_range(0, 3);
        if (($urandom % 3) == 0) g = 0;
        if (g > 0) begin
            s_tvalid <= 0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    function automatic logic [31:0] rand_word(input logic [31:0] pool[$]);
        case ($urandom % 5)
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return pool.size() ? pool[$urandom % pool.size()] : 32'hffff_ffff;
            3: return $urandom_range(0, 6) - 3;
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [31:0] pool[$];
        t_mode       md;
        int          r;
        logic [3:0]  sl;
        logic signed [5:0] sz;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: each status code, extremes of every field
        send(MD_APPEND, 4'd0, 0, 0);
        send(MD_COUNT, 4'd15, 32'hffff_ffff, -6'sd32);
        send(MD_READ, 4'd11, 0, 0);
        send(MD_APPEND, 4'd1, 1, 1);
        send(MD_CREATE, 4'd1, 0, 0);
        send(MD_CREATE, 4'd1, 0, -6'sd16);
        send(MD_CREATE, 4'd1, 0, 6'sd17);
        send(MD_CREATE, 4'd1, 0, 6'sd31);
        send(MD_CREATE, 4'd1, 0, 6'sd2);
        send(MD_CREATE, 4'd1, 0, 6'sd2);
        send(MD_READ, 4'd1, 0, 0);
        send(MD_SORT, 4'd1, 0, 0);
        send(MD_COUNT, 4'd1, 0, 0);
        send(MD_DROP, 4'd1, 0, 0);
        send(MD_REMOVE, 4'd1, 5, 0);
        send(MD_APPEND, 4'd1, 32'h7fff_ffff, 0);
        send(MD_APPEND, 4'd1, 32'h8000_0000, 0);
        send(MD_APPEND, 4'd1, 32'h5555_5555, 0);
        send(MD_SORT, 4'd1, 0, 0);
        send(MD_RESIZE, 4'd1, 0, -6'sd2);
        send(MD_RESIZE, 4'd1, 0, 6'sd15);
        send(MD_RESIZE, 4'd1, 0, -6'sd1);
        send(MD_REMOVE, 4'd1, 32'h8000_0000, 0);
        send(MD_CREATE, 4'd10, 0, 6'sd16);
        send(MD_READ, 4'd1, 0, 0);

        // random: mostly valid slots with appends dominating so lists fill up
        for (int i = 0; i < 300; i++) begin
            if (i == 150) begin
                // long receiver hold-off while requests keep coming
                fork
                    begin
                        hold_off = 1;
                        repeat (300) @(posedge i_clk);
                        hold_off = 0;
                    end
                join_none
            end
            r = $urandom % 100;
            if (r < 8) md = MD_CREATE;
            else if (r < 45) md = MD_APPEND;
            else if (r < 52) md = MD_DROP;
            else if (r < 62) md = MD_REMOVE;
            else if (r < 70) md = MD_RESIZE;
            else if (r < 80) md = MD_READ;
            else if (r < 92) md = MD_SORT;
            else md = MD_COUNT;
            sl = (($urandom % 20) == 0) ? 4'($urandom) : 4'($urandom_range(1, 10));
            if (md == MD_CREATE)
                sz = (($urandom % 6) == 0) ? 6'($urandom) : 6'($urandom_range(1, 16));
            else if (($urandom % 8) == 0)
                sz = 6'($urandom);
            else
                sz = 6'($urandom_range(0, 32) - 16);
            send(md, sl, rand_word(pool), sz);
            if (md == MD_APPEND) pool.push_back(s_tdata[35:4]);
            if (pool.size() > 24) void'(pool.pop_front());
            // occasionally sweep every slot with a shrink far below the minimum
            if (($urandom % 60) == 0)
                for (int k = 1; k <= 10; k++) begin
                    send(MD_RESIZE, 4'(k), 0, -6'sd32);
                end
            gap();
        end
        s_tvalid <= 0;

        while (pending != 0 || hold_off) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        $display("requests sent: %0d, responses checked: %0d", sent, responses);
        $display("covered all modes, error codes, sorted reads and a long output stall");
        if (fail_count == 0 && pending == 0) begin
            $display("** bounded_list_bank: PASSED **");
        end else begin
            $display("** bounded_list_bank: FAILED **");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout");
        $display("** bounded_list_bank: FAILED **");
        $finish;
    end
endmodule
`default_nettype wire
